FILE: sv/hsd_pkg.sv
// Shared types, sizes and helpers for the descending tagged heapsort block.
// Used by the channel interfaces, the RAM users, the controller and the datapath.
package hsd_pkg;

    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CHILD_W = CNT_W + 1;
    localparam int KEY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int ITEM_W  = KEY_W + TAG_W;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [TAG_W-1:0]        t_tag;

    typedef struct packed {
        t_key key;
        t_tag tag;
    } t_item;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_INIT     = 4'd2,
        OP_OUTER    = 4'd3,
        OP_HOLD_A   = 4'd4,
        OP_HOLD_B   = 4'd5,
        OP_SIFT_RD  = 4'd6,
        OP_SIFT_CMP = 4'd7,
        OP_FINAL    = 4'd8,
        OP_EMIT_RD  = 4'd9,
        OP_EMIT_LD  = 4'd10,
        OP_NEXT     = 4'd11,
        OP_DONE     = 4'd12
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic small_set;   // set holds at most one item, nothing to sort
        logic left_gt1;    // heap build phase still running
        logic right_is2;   // extraction leaves a single item
        logic child_in;    // current child lies inside the heap
        logic swap;        // held item sinks below the chosen child
        logic last_emit;   // the item being emitted closes the set
    } t_stat;

    function automatic logic key_gt(input t_key a, input t_key b);
        return $signed(a) > $signed(b);
    endfunction

endpackage

FILE: sv/hsd_stream_if.sv
// Valid/ready channel interfaces for the input items and the sorted results.
// Depends on hsd_pkg for the payload types.
interface hsd_in_if;
    import hsd_pkg::*;

    logic valid;
    logic ready;
    t_key key;
    t_tag tag;
    logic last_in;

    modport source (output valid, key, tag, last_in, input ready);
    modport sink   (input valid, key, tag, last_in, output ready);
endinterface

interface hsd_out_if;
    import hsd_pkg::*;

    logic valid;
    logic ready;
    t_key sorted_key;
    t_tag sorted_tag;
    logic last_out;
    logic overflow;

    modport source (output valid, sorted_key, sorted_tag, last_out, overflow, input ready);
    modport sink   (input valid, sorted_key, sorted_tag, last_out, overflow, output ready);
endinterface

FILE: sv/hsd_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

FILE: sv/hsd_ctrl.sv
// Sequencer for load, heap build, extraction and emit phases.
// Depends on hsd_pkg; drives the datapath through t_cmd, reads back t_stat.
module hsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last_in,
    input  logic           i_out_ready,
    input  hsd_pkg::t_stat i_stat,
    output hsd_pkg::t_cmd  o_cmd,
    output logic           o_in_ready
);
    import hsd_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD      = 11'b000_0000_0001,
        S_INIT      = 11'b000_0000_0010,
        S_OUTER     = 11'b000_0000_0100,
        S_HOLD_A    = 11'b000_0000_1000,
        S_HOLD_B    = 11'b000_0001_0000,
        S_SIFT_RD   = 11'b000_0010_0000,
        S_SIFT_CMP  = 11'b000_0100_0000,
        S_FINAL     = 11'b000_1000_0000,
        S_EMIT_RD   = 11'b001_0000_0000,
        S_EMIT_LD   = 11'b010_0000_0000,
        S_EMIT_WAIT = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    if (i_last_in) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = i_stat.small_set ? S_EMIT_RD : S_OUTER;
            end
            S_OUTER: begin
                o_cmd.op = OP_OUTER;
                n_state  = i_stat.left_gt1 ? S_HOLD_A : S_HOLD_B;
            end
            S_HOLD_A: begin
                o_cmd.op = OP_HOLD_A;
                n_state  = S_SIFT_RD;
            end
            S_HOLD_B: begin
                o_cmd.op = OP_HOLD_B;
                n_state  = i_stat.right_is2 ? S_FINAL : S_SIFT_RD;
            end
            S_SIFT_RD: begin
                o_cmd.op = OP_SIFT_RD;
                n_state  = i_stat.child_in ? S_SIFT_CMP : S_OUTER;
            end
            S_SIFT_CMP: begin
                o_cmd.op = OP_SIFT_CMP;
                n_state  = i_stat.swap ? S_SIFT_RD : S_OUTER;
            end
            S_FINAL: begin
                o_cmd.op = OP_FINAL;
                n_state  = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                o_cmd.op = OP_EMIT_RD;
                n_state  = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                o_cmd.op = OP_EMIT_LD;
                n_state  = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    if (i_stat.last_emit) begin
                        o_cmd.op = OP_DONE;
                        n_state  = S_LOAD;
                    end else begin
                        o_cmd.op = OP_NEXT;
                        n_state  = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end
endmodule

FILE: sv/hsd_datapath.sv
// Item store, heap indices, held item, comparators and the result register.
// Depends on hsd_pkg and hsd_ram; commanded by hsd_ctrl.
module hsd_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hsd_pkg::t_cmd  i_cmd,
    output hsd_pkg::t_stat o_stat,
    input  hsd_pkg::t_key  i_key,
    input  hsd_pkg::t_tag  i_tag,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hsd_pkg::t_key  o_sorted_key,
    output hsd_pkg::t_tag  o_sorted_tag,
    output logic           o_last_out,
    output logic           o_overflow
);
    import hsd_pkg::*;

    logic [CNT_W-1:0]   r_cnt;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_left;
    logic [CNT_W-1:0]   r_right;
    logic [CNT_W-1:0]   r_pos;
    logic [CHILD_W-1:0] r_child;
    logic [ADDR_W-1:0]  r_emit;
    t_item              r_hold;
    logic               r_out_valid;
    t_item              r_out;
    logic               r_out_last;
    logic               r_out_ovf;

    logic                we;
    logic [ADDR_W-1:0]   waddr;
    t_item               wdata;
    logic [ADDR_W-1:0]   raddr_a;
    logic [ADDR_W-1:0]   raddr_b;
    logic [ITEM_W-1:0]   rdata_a;
    logic [ITEM_W-1:0]   rdata_b;
    t_item               rd_a;
    t_item               rd_b;
    logic                use_b;
    t_item               chosen;
    logic [CHILD_W-1:0]  child_p1;
    logic [CNT_W-1:0]    cidx;
    logic [ADDR_W-1:0]   pos_addr;
    logic                store_full;

    hsd_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    assign rd_a = t_item'(rdata_a);
    assign rd_b = t_item'(rdata_b);

    // pick the smaller child; the right one only on a strict win
    assign child_p1   = r_child + CHILD_W'(1);
    assign use_b      = (r_child < CHILD_W'(r_right)) && key_gt(rd_a.key, rd_b.key);
    assign chosen     = use_b ? rd_b : rd_a;
    assign cidx       = use_b ? child_p1[CNT_W-1:0] : r_child[CNT_W-1:0];
    assign pos_addr   = ADDR_W'(r_pos - CNT_W'(1));
    assign store_full = (r_cnt == CNT_W'(DEPTH));

    assign o_stat.small_set = (r_cnt <= CNT_W'(1));
    assign o_stat.left_gt1  = (r_left > CNT_W'(1));
    assign o_stat.right_is2 = (r_right == CNT_W'(2));
    assign o_stat.child_in  = (r_child <= CHILD_W'(r_right));
    assign o_stat.swap      = key_gt(r_hold.key, chosen.key);
    assign o_stat.last_emit = (CNT_W'(r_emit) == r_cnt - CNT_W'(1));

    // RAM address and write steering
    always_comb begin
        we      = 1'b0;
        waddr   = pos_addr;
        wdata   = r_hold;
        raddr_a = r_emit;
        raddr_b = '0;
        unique case (i_cmd.op)
            OP_LOAD: begin
                we       = !store_full;
                waddr    = r_cnt[ADDR_W-1:0];
                wdata.key = i_key;
                wdata.tag = i_tag;
            end
            OP_OUTER: begin
                if (o_stat.left_gt1) begin
                    raddr_a = ADDR_W'(r_left - CNT_W'(2));
                end else begin
                    raddr_a = ADDR_W'(r_right - CNT_W'(1));
                    raddr_b = '0;
                end
            end
            OP_HOLD_B: begin
                we    = 1'b1;
                waddr = ADDR_W'(r_right - CNT_W'(1));
                wdata = rd_b;
            end
            OP_SIFT_RD: begin
                raddr_a = ADDR_W'(r_child - CHILD_W'(1));
                raddr_b = r_child[ADDR_W-1:0];
                we      = !o_stat.child_in;
            end
            OP_SIFT_CMP: begin
                we    = 1'b1;
                wdata = o_stat.swap ? chosen : r_hold;
            end
            OP_FINAL: begin
                we    = 1'b1;
                waddr = '0;
            end
            OP_NONE, OP_INIT, OP_HOLD_A, OP_EMIT_RD, OP_EMIT_LD, OP_NEXT, OP_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_right     <= '0;
            r_pos       <= '0;
            r_child     <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    if (store_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                OP_INIT: begin
                    r_left  <= (r_cnt >> 1) + CNT_W'(1);
                    r_right <= r_cnt;
                end
                OP_OUTER: begin
                    if (o_stat.left_gt1) begin
                        r_left <= r_left - CNT_W'(1);
                    end
                end
                OP_HOLD_A: begin
                    r_hold  <= rd_a;
                    r_pos   <= r_left;
                    r_child <= {r_left, 1'b0};
                end
                OP_HOLD_B: begin
                    r_hold  <= rd_a;
                    r_right <= r_right - CNT_W'(1);
                    r_pos   <= CNT_W'(1);
                    r_child <= CHILD_W'(2);
                end
                OP_SIFT_CMP: begin
                    if (o_stat.swap) begin
                        r_pos   <= cidx;
                        r_child <= {cidx, 1'b0};
                    end
                end
                OP_EMIT_LD: begin
                    r_out       <= rd_a;
                    r_out_last  <= o_stat.last_emit;
                    r_out_ovf   <= r_ovf;
                    r_out_valid <= 1'b1;
                end
                OP_NEXT: begin
                    r_emit <= r_emit + ADDR_W'(1);
                end
                OP_DONE: begin
                    r_emit <= '0;
                    r_cnt  <= '0;
                    r_ovf  <= 1'b0;
                end
                OP_NONE, OP_SIFT_RD, OP_FINAL, OP_EMIT_RD: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sorted_key = r_out.key;
    assign o_sorted_tag = r_out.tag;
    assign o_last_out   = r_out_last;
    assign o_overflow   = r_out_ovf;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("item count beyond store depth");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> store_full)
        else $error("overflow flagged with free store entries");

    a_no_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (i_cmd.op != OP_LOAD))
        else $error("item loaded while a result is pending");

    a_cmp_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SIFT_CMP) |-> (r_child <= CHILD_W'(r_right)))
        else $error("child compare outside the heap");
`endif
endmodule

FILE: sv/heapsort_descending_with_tags_unit.sv
// Descending heapsort of tagged Q16.16 keys. Load: one input item per cycle while loading.
// Sort: a setup step, then per heap iteration an outer step, a hold step and a read and a
// compare per level sunk; the sift stops on a read or on a compare that does not swap.
// Emit: read, load and output wait per result; input waits until the last result leaves.
// Reset: synchronous, active low; clears counts, flags and the sequencer, not the store.
// Depends on hsd_pkg, hsd_stream_if, hsd_ram, hsd_ctrl and hsd_datapath.
module heapsort_descending_with_tags_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hsd_in_if.sink     i_in,
    hsd_out_if.source  o_out
);
    import hsd_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // Controller: walks load -> build -> extract -> emit, one transaction at a time.
    hsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_last_in   (i_in.last_in),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready)
    );

    assign i_in.ready = in_ready;

    // Datapath: item store, heap pointers and the result register.
    hsd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_key        (i_in.key),
        .i_tag        (i_in.tag),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_sorted_key (o_out.sorted_key),
        .o_sorted_tag (o_out.sorted_tag),
        .o_last_out   (o_out.last_out),
        .o_overflow   (o_out.overflow)
    );
endmodule
